// ===== hdl/ptyc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptyc_pkg: shared types and constants for the palette to YCbCr 4:2:2 block
// Colour table geometry, conversion coefficients, exact reciprocals for the
// fixed divisions, the command queue format and the gamma curve ROM.
// ----------------------------------------------------------------------------
package ptyc_pkg;

    // Colour table
    localparam int TABLE_ENTRIES = 256;
    localparam int TAB_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TAB_W         = 24;

    // Command queue between front and back
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result buffer in the back part
    localparam int OUT_DEPTH = 4;
    localparam int OAW       = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    // Item kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Luma sum: 299 r + 587 g + 114 b, at most 255000
    localparam int YNUM_W = 18;
    localparam logic [YNUM_W-1:0] KY_R = YNUM_W'(299);
    localparam logic [YNUM_W-1:0] KY_G = YNUM_W'(587);
    localparam logic [YNUM_W-1:0] KY_B = YNUM_W'(114);

    // Chroma numerators, always in 50000..25550000, so 25 bits modulo arithmetic
    localparam int CNUM_W = 25;
    localparam logic [CNUM_W-1:0] KC_OFS = CNUM_W'(12800000);
    localparam logic [CNUM_W-1:0] KCB_R  = CNUM_W'(16874);
    localparam logic [CNUM_W-1:0] KCB_G  = CNUM_W'(33126);
    localparam logic [CNUM_W-1:0] KCB_B  = CNUM_W'(50000);
    localparam logic [CNUM_W-1:0] KCR_R  = CNUM_W'(50000);
    localparam logic [CNUM_W-1:0] KCR_G  = CNUM_W'(41869);
    localparam logic [CNUM_W-1:0] KCR_B  = CNUM_W'(8131);

    // Divide by 1000: ceil(2^28 / 1000), exact for numerators below 493447
    localparam int YREC_W     = 19;
    localparam int RECIP_Y_SH = 28;
    localparam logic [YREC_W-1:0] RECIP_Y = YREC_W'(268436);
    localparam int YPROD_W    = YNUM_W + YREC_W;

    // Divide by 100000: ceil(2^41 / 100000), exact for numerators below 2^25
    localparam int CREC_W     = 25;
    localparam int RECIP_C_SH = 41;
    localparam logic [CREC_W-1:0] RECIP_C = CREC_W'(21990233);
    localparam int CPROD_W    = CNUM_W + CREC_W;

    typedef struct packed {
        logic        op;
        logic [7:0]  idx;
        logic [31:0] data;
    } t_cmd;

    typedef struct packed {
        logic              not_empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    typedef logic [255:0][7:0] t_gamma;

    // floor(sqrt(255 * i)), one root bit per step
    function automatic t_gamma build_gamma();
        t_gamma     g;
        logic [15:0] v;
        logic [7:0]  root;
        logic [7:0]  trial;
        for (int i = 0; i < 256; i++) begin
            v    = 16'(i * 255);
            root = '0;
            for (int b = 7; b >= 0; b--) begin
                trial = root | 8'(1 << b);
                if (16'(trial) * 16'(trial) <= v) begin
                    root = trial;
                end
            end
            g[i] = root;
        end
        return g;
    endfunction

    localparam t_gamma GAMMA = build_gamma();

endpackage
`default_nettype wire

// ===== hdl/ptyc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptyc_ram: generic RAM
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module ptyc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                            o_rdata_a,
    output logic [WIDTH-1:0]                            o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// ===== hdl/ptyc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptyc_front: input stage and colour conversion
// Accepts items, runs load colours through a three stage RGB to YCbCr
// pipeline and pushes commands into the queue. Credit-based stall.
// ----------------------------------------------------------------------------
module ptyc_front
    import ptyc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_entry_index,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [31:0] i_pixel_word,
    input  wire t_q_status   i_q_status,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic        r_s1_valid, r_s2_valid, r_s3_valid;
    logic        r_s1_op, r_s2_op, r_s3_op;
    logic [7:0]  r_s1_idx, r_s2_idx, r_s3_idx;
    logic [31:0] r_s1_word, r_s2_word, r_s3_word;
    logic [7:0]  r_s1_red, r_s1_green, r_s1_blue;

    logic [YNUM_W-1:0]  r_s2_ynum;
    logic [CNUM_W-1:0]  r_s2_cbnum, r_s2_crnum;
    logic [YPROD_W-1:0] r_s3_yprod;
    logic [CPROD_W-1:0] r_s3_cbprod, r_s3_crprod;

    logic [YNUM_W-1:0] n_ynum;
    logic [CNUM_W-1:0] n_cbnum, n_crnum;
    logic [QCNT_W:0]   used;
    logic              accept;

    // Every queue slot is spoken for by an item in the queue or in the pipe
    assign used = {1'b0, i_q_status.count} + (QCNT_W + 1)'(r_s1_valid)
                + (QCNT_W + 1)'(r_s2_valid) + (QCNT_W + 1)'(r_s3_valid);
    assign o_stall = (used >= (QCNT_W + 1)'(QDEPTH));
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_ynum  = YNUM_W'(r_s1_red) * KY_R + YNUM_W'(r_s1_green) * KY_G
                + YNUM_W'(r_s1_blue) * KY_B;
        n_cbnum = KC_OFS + CNUM_W'(r_s1_blue) * KCB_B
                - CNUM_W'(r_s1_red) * KCB_R - CNUM_W'(r_s1_green) * KCB_G;
        n_crnum = KC_OFS + CNUM_W'(r_s1_red) * KCR_R
                - CNUM_W'(r_s1_green) * KCR_G - CNUM_W'(r_s1_blue) * KCR_B;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= i_op;
            r_s1_idx   <= i_entry_index;
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
            r_s1_word  <= i_pixel_word;
        end
        r_s2_op     <= r_s1_op;
        r_s2_idx    <= r_s1_idx;
        r_s2_word   <= r_s1_word;
        r_s2_ynum   <= n_ynum;
        r_s2_cbnum  <= n_cbnum;
        r_s2_crnum  <= n_crnum;
        r_s3_op     <= r_s2_op;
        r_s3_idx    <= r_s2_idx;
        r_s3_word   <= r_s2_word;
        r_s3_yprod  <= YPROD_W'(r_s2_ynum) * YPROD_W'(RECIP_Y);
        r_s3_cbprod <= CPROD_W'(r_s2_cbnum) * CPROD_W'(RECIP_C);
        r_s3_crprod <= CPROD_W'(r_s2_crnum) * CPROD_W'(RECIP_C);
    end

    always_comb begin
        o_push     = r_s3_valid;
        o_cmd.op   = r_s3_op;
        o_cmd.idx  = r_s3_idx;
        if (r_s3_op == OP_PIXEL) begin
            o_cmd.data = r_s3_word;
        end else begin
            o_cmd.data = {8'd0, GAMMA[r_s3_yprod[RECIP_Y_SH +: 8]],
                          r_s3_cbprod[RECIP_C_SH +: 8], r_s3_crprod[RECIP_C_SH +: 8]};
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ptyc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptyc_queue: command queue
// Small register FIFO that decouples the conversion front from the
// table and pair back part.
// ----------------------------------------------------------------------------
module ptyc_queue
    import ptyc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_pop,
    output t_cmd       o_head,
    output t_q_status  o_status
);

    t_cmd              r_mem [QDEPTH];
    logic [QAW-1:0]    r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_head             = r_mem[r_rptr];
    assign o_status.count     = r_count;
    assign o_status.not_empty = (r_count != '0);

endmodule
`default_nettype wire

// ===== hdl/ptyc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptyc_back: colour table and pair builder
// Writes load commands into the colour table, reads two entries per pair
// for pixel commands, averages chroma and buffers results for output.
// ----------------------------------------------------------------------------
module ptyc_back
    import ptyc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_double_width,
    input  wire t_q_status   i_q_status,
    input  wire t_cmd        i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_pair_word,
    output logic             o_last
);

    logic [1:0]        r_pair;
    logic              r_rd_valid, r_rd_last, r_a_ok, r_b_ok;
    logic [31:0]       r_out_word [OUT_DEPTH];
    logic              r_out_last [OUT_DEPTH];
    logic [OAW-1:0]    r_ow_ptr, r_or_ptr;
    logic [OCNT_W-1:0] r_out_count;

    logic              head_load, head_pixel, credit_ok, issue, last_pair, out_pop;
    logic [1:0]        sel_a, sel_b;
    logic [7:0]        idx_a, idx_b;
    logic              a_ok, b_ok, wr_ok;
    logic [TAB_W-1:0]  rd_a, rd_b, ent_a, ent_b;
    logic [8:0]        cb_sum, cr_sum;
    logic [31:0]       pair;

    function automatic logic [7:0] pick_byte(input logic [31:0] w, input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    assign head_load  = i_q_status.not_empty && (i_head.op == OP_LOAD);
    assign head_pixel = i_q_status.not_empty && (i_head.op == OP_PIXEL);
    assign credit_ok  = (({1'b0, r_out_count} + (OCNT_W + 1)'(r_rd_valid))
                         < (OCNT_W + 1)'(OUT_DEPTH));
    assign issue      = head_pixel && credit_ok;
    assign last_pair  = i_double_width ? (r_pair == 2'd3) : (r_pair == 2'd1);
    assign o_pop      = head_load || (issue && last_pair);

    // Double width repeats one index; single width takes two neighbors
    assign sel_a = i_double_width ? r_pair : {r_pair[0], 1'b0};
    assign sel_b = i_double_width ? r_pair : {r_pair[0], 1'b1};
    assign idx_a = pick_byte(i_head.data, sel_a);
    assign idx_b = pick_byte(i_head.data, sel_b);
    assign a_ok  = ({1'b0, idx_a} < 9'(TABLE_ENTRIES));
    assign b_ok  = ({1'b0, idx_b} < 9'(TABLE_ENTRIES));
    assign wr_ok = ({1'b0, i_head.idx} < 9'(TABLE_ENTRIES));

    ptyc_ram #(
        .WIDTH (TAB_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (head_load && wr_ok),
        .i_waddr   (i_head.idx[TAB_AW-1:0]),
        .i_wdata   (i_head.data[TAB_W-1:0]),
        .i_raddr_a (idx_a[TAB_AW-1:0]),
        .i_raddr_b (idx_b[TAB_AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
            if (issue) begin
                r_pair <= last_pair ? 2'd0 : r_pair + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= last_pair;
        r_a_ok    <= a_ok;
        r_b_ok    <= b_ok;
    end

    // Entries beyond the table read as zero
    always_comb begin
        ent_a  = r_a_ok ? rd_a : '0;
        ent_b  = r_b_ok ? rd_b : '0;
        cb_sum = 9'(ent_a[15:8]) + 9'(ent_b[15:8]);
        cr_sum = 9'(ent_a[7:0]) + 9'(ent_b[7:0]);
        pair   = {ent_a[23:16], cb_sum[8:1], ent_b[23:16], cr_sum[8:1]};
    end

    assign out_pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ow_ptr    <= '0;
            r_or_ptr    <= '0;
            r_out_count <= '0;
        end else begin
            if (r_rd_valid) begin
                r_ow_ptr <= r_ow_ptr + OAW'(1);
            end
            if (out_pop) begin
                r_or_ptr <= r_or_ptr + OAW'(1);
            end
            r_out_count <= r_out_count + OCNT_W'(r_rd_valid) - OCNT_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_out_word[r_ow_ptr] <= pair;
            r_out_last[r_ow_ptr] <= r_rd_last;
        end
    end

    assign o_valid     = (r_out_count != '0);
    assign o_pair_word = r_out_word[r_or_ptr];
    assign o_last      = r_out_last[r_or_ptr];

`ifndef SYNTHESIS
    a_no_buffer_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_out_count != OCNT_W'(OUT_DEPTH)))
        else $error("result buffer overflow");

    a_last_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && last_pair) |=> (r_rd_valid && r_rd_last))
        else $error("final pair not flagged");

    a_pair_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.not_empty |-> (r_pair == 2'd0))
        else $error("pair counter left mid item");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_status.not_empty)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== hdl/palette_to_ycbcr422_converter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palette_to_ycbcr422_converter_top: palette lookup with YCbCr 4:2:2 output
// Input channel (i_valid / o_stall) takes load and pixel items. A load item
// converts an RGB colour to Y (gamma curve on the luma sum), Cb and Cr and
// writes it into the 256 entry colour table; it gives no result. A pixel
// item carries four indices and gives two Y1CbY2Cr pairs, or four when
// double width is set, the final one with o_last high.
// Output channel (o_valid / i_stall) moves one pair per cycle unless stalled.
// An item's first pair passes the front pipeline, the command queue, the table
// read register and the result buffer before o_valid rises. Loads are taken
// one per cycle while nothing stalls; a pixel item holds the queue head until
// its last pair is read, with one read of two table entries per pair. A stalled
// receiver fills the four entry result buffer; o_stall rises once the queued
// and in-flight commands fill the eight entry queue. Reset empties the pipeline
// and queues and clears double width; table contents stay undefined until
// loaded. The config channel is always ready and must only be written idle.
// ----------------------------------------------------------------------------
module palette_to_ycbcr422_converter_top
    import ptyc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_entry_index,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [31:0] i_pixel_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_pair_word,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_double_width
);

    logic      r_double_width;
    logic      push, pop;
    t_cmd      push_cmd, head;
    t_q_status q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_double_width <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_double_width <= i_cfg_double_width;
        end
    end

    ptyc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_pixel_word  (i_pixel_word),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    ptyc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    ptyc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_double_width (r_double_width),
        .i_q_status     (q_status),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pair_word    (o_pair_word),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire
